// ----- hdl/lsa_pkg.sv -----
`timescale 1ns / 1ps

package lsa_pkg;

  // Fixed-point format of every matrix, right-hand side and solution element.
  localparam int FracBits = 16;
  localparam int InW      = 32;

  // Exact widths of the intermediate integers.
  localparam int ProdW    = 2 * InW;            // product of two entries
  localparam int CofW     = ProdW + 1;          // cofactor, difference of two products
  localparam int LoW      = InW;                // low slice of a cofactor
  localparam int HiW      = CofW - LoW;         // signed high slice of a cofactor
  localparam int PartW    = InW + HiW;          // partial product width
  localparam int DetW     = InW + CofW + 1;     // determinant and numerators, signed
  localparam int AbsW     = DetW - 1;           // magnitudes
  localparam int ShiftW   = FracBits + 1;       // pre-scale of the numerator
  localparam int NumW     = AbsW + ShiftW + 1;  // scaled numerator plus rounding term
  localparam int DivW     = AbsW + 1;           // divisor, twice the determinant magnitude
  localparam int QBits    = InW + 1;            // quotient bits resolved by the divider
  localparam int RemW     = DivW + 1;           // partial remainder
  localparam int ThrW     = 63;                 // threshold register

  // Stage counts.
  localparam int FrontStages = 6;
  localparam int DivStages   = QBits + 2;

  // Configuration register map.
  localparam int          AddrW       = 4;
  localparam int          CfgDataW    = 64;
  localparam logic [AddrW-1:0] AddrThreshold = 4'h0;
  localparam logic [ThrW-1:0]  ThrReset      = 63'd1;

  typedef logic signed [InW-1:0] fix_t;

  // One solution lane handed from the front end to a divider.
  typedef struct packed {
    logic            sing;
    logic            neg;
    logic [NumW-1:0] num;
    logic [DivW-1:0] den;
  } lane_t;

endpackage

// ----- hdl/lsa_front.sv -----
`timescale 1ns / 1ps

module lsa_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    vld_i,
  input  lsa_pkg::fix_t           mat_i [9],
  input  lsa_pkg::fix_t           rhs_i [3],
  input  logic [lsa_pkg::ThrW-1:0] thr_i,
  output logic                    vld_o,
  output lsa_pkg::lane_t          lane_o [3]
);

  localparam int ProdW = lsa_pkg::ProdW;
  localparam int CofW  = lsa_pkg::CofW;
  localparam int LoW   = lsa_pkg::LoW;
  localparam int PartW = lsa_pkg::PartW;
  localparam int DetW  = lsa_pkg::DetW;
  localparam int AbsW  = lsa_pkg::AbsW;
  localparam int NumW  = lsa_pkg::NumW;

  logic [lsa_pkg::FrontStages-1:0] vld_q;

  // Stage 1: the eighteen entry products of the cofactors.
  logic signed [ProdW-1:0] pa_q [9];
  logic signed [ProdW-1:0] pb_q [9];
  lsa_pkg::fix_t           mc1_q [3];
  lsa_pkg::fix_t           b1_q  [3];

  for (genvar i = 0; i < 3; i++) begin : g_cof_i
    for (genvar j = 0; j < 3; j++) begin : g_cof_j
      localparam int R1 = (j + 1) % 3;
      localparam int R2 = (j + 2) % 3;
      localparam int C1 = (i + 1) % 3;
      localparam int C2 = (i + 2) % 3;
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          pa_q[i*3+j] <= mat_i[R1*3+C1] * mat_i[R2*3+C2];
          pb_q[i*3+j] <= mat_i[R1*3+C2] * mat_i[R2*3+C1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int t = 0; t < 3; t++) begin
        mc1_q[t] <= mat_i[t*3];
        b1_q[t]  <= rhs_i[t];
      end
    end
  end

  // Stage 2: cofactors, held as the adjugate in row-major order.
  logic signed [CofW-1:0] adj_q [9];
  lsa_pkg::fix_t          mc2_q [3];
  lsa_pkg::fix_t          b2_q  [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 9; k++) begin
        adj_q[k] <= CofW'(pa_q[k]) - CofW'(pb_q[k]);
      end
      mc2_q <= mc1_q;
      b2_q  <= b1_q;
    end
  end

  // Stage 3: split partial products for the determinant and the numerators.
  logic signed [PartW-1:0] dlo_q [3];
  logic signed [PartW-1:0] dhi_q [3];
  logic signed [PartW-1:0] nlo_q [9];
  logic signed [PartW-1:0] nhi_q [9];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int t = 0; t < 3; t++) begin
        dlo_q[t] <= mc2_q[t] * $signed({1'b0, adj_q[t][LoW-1:0]});
        dhi_q[t] <= mc2_q[t] * $signed(adj_q[t][CofW-1:LoW]);
      end
      for (int k = 0; k < 9; k++) begin
        nlo_q[k] <= b2_q[k%3] * $signed({1'b0, adj_q[k][LoW-1:0]});
        nhi_q[k] <= b2_q[k%3] * $signed(adj_q[k][CofW-1:LoW]);
      end
    end
  end

  // Stage 4: recombine the partial products and sum them.
  logic signed [DetW-1:0] det_d;
  logic signed [DetW-1:0] num_d [3];
  logic signed [DetW-1:0] det_q;
  logic signed [DetW-1:0] num_q [3];

  always_comb begin
    det_d = '0;
    for (int t = 0; t < 3; t++) begin
      det_d = det_d + (DetW'(dhi_q[t]) <<< LoW) + DetW'(dlo_q[t]);
    end
    for (int i = 0; i < 3; i++) begin
      num_d[i] = '0;
      for (int j = 0; j < 3; j++) begin
        num_d[i] = num_d[i] + (DetW'(nhi_q[i*3+j]) <<< LoW) + DetW'(nlo_q[i*3+j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      det_q <= det_d;
      num_q <= num_d;
    end
  end

  // Stage 5: magnitudes, signs and the singular test.
  logic signed [DetW-1:0] det_neg;
  logic signed [DetW-1:0] num_neg [3];
  logic [AbsW-1:0]        adet_q;
  logic [AbsW-1:0]        anum_q [3];
  logic                   neg5_q [3];
  logic                   sing5_q;
  logic [AbsW-1:0]        adet_d;

  always_comb begin
    det_neg = -det_q;
    adet_d  = det_q[DetW-1] ? det_neg[AbsW-1:0] : det_q[AbsW-1:0];
    for (int i = 0; i < 3; i++) begin
      num_neg[i] = -num_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      adet_q  <= adet_d;
      sing5_q <= (det_q == '0) || (adet_d < AbsW'(thr_i));
      for (int i = 0; i < 3; i++) begin
        anum_q[i] <= num_q[i][DetW-1] ? num_neg[i][AbsW-1:0] : num_q[i][AbsW-1:0];
        neg5_q[i] <= (num_q[i][DetW-1] != det_q[DetW-1]) && (num_q[i] != '0);
      end
    end
  end

  // Stage 6: scaled numerator with the half-divisor rounding term, and the divisor.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        lane_o[i].sing <= sing5_q;
        lane_o[i].neg  <= neg5_q[i];
        lane_o[i].num  <= (NumW'(anum_q[i]) << lsa_pkg::ShiftW) + NumW'(adet_q);
        lane_o[i].den  <= {adet_q, 1'b0};
      end
    end
  end

  // Valid bits travel alongside the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[lsa_pkg::FrontStages-2:0], vld_i};
    end
  end

  assign vld_o = vld_q[lsa_pkg::FrontStages-1];

endmodule

// ----- hdl/lsa_div.sv -----
`timescale 1ns / 1ps

module lsa_div (
  input  logic           clk_i,
  input  logic           en_i,
  input  lsa_pkg::lane_t lane_i,
  output lsa_pkg::fix_t  sol_o
);

  localparam int QBits = lsa_pkg::QBits;
  localparam int RemW  = lsa_pkg::RemW;
  localparam int DivW  = lsa_pkg::DivW;
  localparam int NumW  = lsa_pkg::NumW;
  localparam int InW   = lsa_pkg::InW;
  localparam int CmpW  = DivW + QBits;

  logic [RemW-1:0]  rem_q  [QBits+1];
  logic [QBits-1:0] quo_q  [QBits+1];
  logic [QBits-1:0] nlow_q [QBits+1];
  logic [DivW-1:0]  den_q  [QBits+1];
  logic             over_q [QBits+1];
  logic             sing_q [QBits+1];
  logic             neg_q  [QBits+1];

  // Entry stage: flag quotients of 2^QBits or more, load the top of the numerator.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      over_q[0] <= CmpW'(lane_i.num) >= {lane_i.den, {QBits{1'b0}}};
      rem_q[0]  <= RemW'(lane_i.num[NumW-1:QBits]);
      nlow_q[0] <= lane_i.num[QBits-1:0];
      quo_q[0]  <= '0;
      den_q[0]  <= lane_i.den;
      sing_q[0] <= lane_i.sing;
      neg_q[0]  <= lane_i.neg;
    end
  end

  // One restoring step per stage, most significant quotient bit first.
  for (genvar s = 1; s <= QBits; s++) begin : g_step
    logic [RemW-1:0] trial;
    logic            fits;

    always_comb begin
      trial = {rem_q[s-1][RemW-2:0], nlow_q[s-1][QBits-s]};
      fits  = trial >= RemW'(den_q[s-1]);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= fits ? (trial - RemW'(den_q[s-1])) : trial;
        quo_q[s]  <= {quo_q[s-1][QBits-2:0], fits};
        nlow_q[s] <= nlow_q[s-1];
        den_q[s]  <= den_q[s-1];
        over_q[s] <= over_q[s-1];
        sing_q[s] <= sing_q[s-1];
        neg_q[s]  <= neg_q[s-1];
      end
    end
  end

  // Final stage: saturate, apply the sign, force zero when singular.
  logic [InW-1:0] mag;
  logic [InW-1:0] lim;
  logic           sat;
  logic [InW-1:0] res;

  always_comb begin
    lim = neg_q[QBits] ? {1'b1, {(InW-1){1'b0}}} : {1'b0, {(InW-1){1'b1}}};
    sat = over_q[QBits] || quo_q[QBits][QBits-1] || (quo_q[QBits][InW-1:0] > lim);
    mag = sat ? lim : quo_q[QBits][InW-1:0];
    res = neg_q[QBits] ? (~mag + 1'b1) : mag;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sol_o <= sing_q[QBits] ? '0 : $signed(res);
    end
  end

endmodule

// ----- hdl/linear_solve_3x3_adjugate.sv -----
`timescale 1ns / 1ps

// Solves A*x = b for a 3x3 system in signed Q16.16 through the adjugate.
// Input channel: one beat carries the nine matrix entries, row by row, and
// the three right-hand-side entries. Output channel: one beat per input beat
// carries the three solution elements, rounded to nearest with ties away
// from zero and saturated to 32 bits, plus a singular flag in tuser. When
// |det(A)| is below the threshold register, or det(A) is zero, the flag is
// set and the solution is zero.
// Six front-end stages (products, cofactors, split partial products, sums,
// magnitudes, scaling) lead into 35 divider stages: an entry stage, one
// restoring step per quotient bit and an output stage, with one divider
// per solution element. Throughput is one system per cycle while the
// output is not stalled.
// The whole pipeline advances together: while an output beat waits for
// tready, every stage holds and s_axis_tready is low, so nothing is lost or
// repeated. Reset empties the pipeline and sets the threshold to 1.
// The threshold sits at byte address 0 of the register port.

module linear_solve_3x3_adjugate (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // a_row0_col0, a_row0_col1, a_row0_col2, a_row1_col0, a_row1_col1,
  // a_row1_col2, a_row2_col0, a_row2_col1, a_row2_col2, rhs_0, rhs_1, rhs_2
  input  logic [12*lsa_pkg::InW-1:0]    s_axis_tdata,
  // Output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // solution_0, solution_1, solution_2
  output logic [3*lsa_pkg::InW-1:0]     m_axis_tdata,
  // singular
  output logic                          m_axis_tuser,
  // Register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lsa_pkg::AddrW-1:0]     paddr,
  input  logic [lsa_pkg::CfgDataW-1:0]  pwdata,
  output logic [lsa_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready
);

  localparam int InW = lsa_pkg::InW;
  localparam int DivStages = lsa_pkg::DivStages;

  // Threshold register.
  logic [lsa_pkg::ThrW-1:0] thr_q;

  assign pready = 1'b1;
  assign prdata = (paddr == lsa_pkg::AddrThreshold) ?
                  lsa_pkg::CfgDataW'(thr_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= lsa_pkg::ThrReset;
    end else if (psel && penable && pwrite && pready &&
                 (paddr == lsa_pkg::AddrThreshold)) begin
      thr_q <= pwdata[lsa_pkg::ThrW-1:0];
    end
  end

  // Global advance: the pipeline moves unless the output beat is stalled.
  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // Unpack the input beat.
  lsa_pkg::fix_t mat [9];
  lsa_pkg::fix_t rhs [3];

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      mat[k] = s_axis_tdata[k*InW +: InW];
    end
    for (int t = 0; t < 3; t++) begin
      rhs[t] = s_axis_tdata[(9+t)*InW +: InW];
    end
  end

  // Front end: cofactors, determinant, numerators and divider operands.
  logic           front_vld;
  lsa_pkg::lane_t lane [3];

  lsa_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s_axis_tvalid && s_axis_tready),
    .mat_i  (mat),
    .rhs_i  (rhs),
    .thr_i  (thr_q),
    .vld_o  (front_vld),
    .lane_o (lane)
  );

  // One divider per solution element.
  lsa_pkg::fix_t sol [3];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    lsa_div u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .lane_i (lane[i]),
      .sol_o  (sol[i])
    );
  end

  // Valid bits and the singular flag through the divider stages.
  logic [DivStages-1:0] vld_q;
  logic [DivStages-1:0] sing_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[DivStages-2:0], front_vld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sing_q <= {sing_q[DivStages-2:0], lane[0].sing};
    end
  end

  assign m_axis_tvalid = vld_q[DivStages-1];
  assign m_axis_tuser  = sing_q[DivStages-1];
  assign m_axis_tdata  = {sol[2], sol[1], sol[0]};

endmodule

// ----- hdl/lsa_chk.sv -----
`timescale 1ns / 1ps

module lsa_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [3*lsa_pkg::InW-1:0]    m_axis_tdata,
  input logic                         m_axis_tuser
);

  // A stalled output beat holds its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                        && $stable(m_axis_tuser))
    else $error("stalled output beat changed");

  // A singular system always reports an all-zero solution.
  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("singular beat carries a non-zero solution");

  // With no output beat pending the block always takes input.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output stage");

  // Input is held off while the output beat is stalled.
  a_backpress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while the output is stalled");

  // Leaving reset, the pipeline is empty.
  a_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("output beat present straight after reset");

endmodule

bind linear_solve_3x3_adjugate lsa_chk u_lsa_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
